### hw/rtl/spq_pkg.sv
// sorted priority queue package: sizes, command and status codes, dp command struct
// no dependencies
`default_nettype none

package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int ID_WIDTH  = 8;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_PEEK   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // latch the accepted input beat
        logic exec;   // apply the latched command and load the result
    } t_dp_cmd;

endpackage

`default_nettype wire

### hw/rtl/spq_ctrl.sv
// sorted priority queue controller: two-state sequencer and result valid flag
// depends on spq_pkg
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_dp_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_exec;

    // result register is free or being emptied this cycle
    assign can_exec = !r_out_valid || i_out_ready;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_dp_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_dp_cmd.exec   = (r_state == S_EXEC) && can_exec;

    // next state and result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_exec) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a result appears only after an execute cycle
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result valid without execute");

    // a blocked execute keeps its command
    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !can_exec) |=> (r_state == S_EXEC))
        else $error("execute dropped while result stalled");

    // an undelivered result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_dp_cmd.exec)
        else $error("result overwritten");

endmodule

`default_nettype wire

### hw/rtl/spq_dp.sv
// sorted priority queue datapath: slot registers, per-slot compare, shift, result register
// depends on spq_pkg
`default_nettype none

module spq_dp
    import spq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_dp_cmd,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [ID_WIDTH-1:0]  i_job_id,
    input  wire logic [KEY_WIDTH-1:0] i_job_key,
    output logic [STAT_W-1:0]         o_status,
    output logic [ID_WIDTH-1:0]       o_out_id,
    output logic [KEY_WIDTH-1:0]      o_out_key,
    output logic [CNT_W-1:0]          o_occupancy
);

    // latched command beat
    t_cmd                 r_cmd;
    logic [ID_WIDTH-1:0]  r_id;
    logic [KEY_WIDTH-1:0] r_key;

    // sorted slots, slot 0 is the head
    logic [KEY_WIDTH-1:0] r_slot_key [DEPTH];
    logic [ID_WIDTH-1:0]  r_slot_id  [DEPTH];
    logic [KEY_WIDTH-1:0] n_slot_key [DEPTH];
    logic [ID_WIDTH-1:0]  n_slot_id  [DEPTH];
    logic [CNT_W-1:0]     r_count, n_count;

    // result register
    logic [STAT_W-1:0]    r_status, n_status;
    logic [ID_WIDTH-1:0]  r_out_id, n_out_id;
    logic [KEY_WIDTH-1:0] r_out_key, n_out_key;

    logic [DEPTH-1:0] occ;       // slot holds an entry
    logic [DEPTH-1:0] stay;      // occupied slot that stays ahead of the new entry
    logic [DEPTH-1:0] hit;       // occupied slot whose id matches
    logic [DEPTH-1:0] hit_incl;  // a match at or before this slot
    logic [DEPTH-1:0] first_hit; // the match nearest the head
    logic             full, empty, found;
    logic [KEY_WIDTH-1:0] rm_key;
    logic [ID_WIDTH-1:0]  rm_id;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // per-slot compares, all slots in parallel
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            occ[i] = (CNT_W'(i) < r_count);
            if (r_key == r_slot_key[i]) begin
                stay[i] = occ[i] && !(r_id < r_slot_id[i]);
            end else begin
                stay[i] = occ[i] && !(r_key < r_slot_key[i]);
            end
            hit[i] = occ[i] && (r_slot_id[i] == r_id);
        end
        for (int i = 0; i < DEPTH; i++) begin
            hit_incl[i]  = |(hit & ~({DEPTH{1'b1}} << i)) | hit[i];
            first_hit[i] = hit[i] && !(|(hit & ~({DEPTH{1'b1}} << i)));
        end
    end

    assign found = hit_incl[DEPTH-1];

    // one-hot select of the matched entry
    always_comb begin
        rm_key = '0;
        rm_id  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_hit[i]) begin
                rm_key = rm_key | r_slot_key[i];
                rm_id  = rm_id | r_slot_id[i];
            end
        end
    end

    // next slots, count and result
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_slot_key[i] = r_slot_key[i];
            n_slot_id[i]  = r_slot_id[i];
        end
        n_count   = r_count;
        n_status  = ST_OK;
        n_out_id  = '0;
        n_out_key = '0;
        case (r_cmd)
            CMD_PUSH: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    // slots behind the insert point move back by one
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!stay[i]) begin
                            if (i == 0) begin
                                n_slot_key[i] = r_key;
                                n_slot_id[i]  = r_id;
                            end else if (stay[(i == 0) ? 0 : i - 1]) begin
                                n_slot_key[i] = r_key;
                                n_slot_id[i]  = r_id;
                            end else begin
                                n_slot_key[i] = r_slot_key[(i == 0) ? 0 : i - 1];
                                n_slot_id[i]  = r_slot_id[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_id  = r_slot_id[0];
                    n_out_key = r_slot_key[0];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_slot_key[i] = r_slot_key[i+1];
                        n_slot_id[i]  = r_slot_id[i+1];
                    end
                    n_count = r_count - 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (!found) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_out_id  = rm_id;
                    n_out_key = rm_key;
                    // slots from the match on close the gap
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (hit_incl[i]) begin
                            n_slot_key[i] = r_slot_key[i+1];
                            n_slot_id[i]  = r_slot_id[i+1];
                        end
                    end
                    n_count = r_count - 1'b1;
                end
            end
            CMD_PEEK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_id  = r_slot_id[0];
                    n_out_key = r_slot_key[0];
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // input beat latch
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd <= t_cmd'(i_cmd);
            r_id  <= i_job_id;
            r_key <= i_job_key;
        end
    end

    // slot storage and result payload
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_slot_key[i] <= n_slot_key[i];
                r_slot_id[i]  <= n_slot_id[i];
            end
            r_status  <= n_status;
            r_out_id  <= n_out_id;
            r_out_key <= n_out_key;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_out_key   = r_out_key;
    assign o_occupancy = r_count;

    // count stays within the slot range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // count moves only on execute
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_dp_cmd.exec |=> $stable(r_count))
        else $error("entry count changed without execute");

    // pop of a non-empty queue drops exactly one entry
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.exec && r_cmd == CMD_POP && r_count != '0)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not drop one entry");

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_queue_top.sv
// sorted priority queue top level: controller plus slot datapath
// depends on spq_pkg, spq_ctrl, spq_dp
// the accepted input beat is latched, then the sequencer executes and loads the result
//   register and result valid; a result still waiting holds the execute state
// a new input beat is taken only once the previous one has executed; in the execute
//   state all slots compare and shift in parallel
// the next input beat is taken while a result waits in the output register
// reset: synchronous active-low, empties the queue; slot contents are not cleared
`default_nettype none

module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [ID_WIDTH-1:0]  i_job_id,
    input  wire logic [KEY_WIDTH-1:0] i_job_key,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [STAT_W-1:0]         o_status,
    output logic [ID_WIDTH-1:0]       o_out_id,
    output logic [KEY_WIDTH-1:0]      o_out_key,
    output logic [CNT_W-1:0]          o_occupancy
);

    t_dp_cmd dp_cmd;

    // sequencer
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dp_cmd    (dp_cmd)
    );

    // slots and result register
    spq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_cmd    (dp_cmd),
        .i_cmd       (i_cmd),
        .i_job_id    (i_job_id),
        .i_job_key   (i_job_key),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_out_key   (o_out_key),
        .o_occupancy (o_occupancy)
    );

endmodule

`default_nettype wire
